// ----- src/bpa_pkg.sv -----
package bpa_pkg;

	localparam int POOL_PAGES_DEF = 4096;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_RUN_DEF    = 64;

	localparam int ROW_BITS = 8;

	localparam int USABLE_W = 13;
	localparam int ADDR_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [USABLE_W-1:0] USABLE_RST    = 13'd4096;
	localparam logic [ADDR_W-1:0]   PHYS_BASE_RST = 32'h0020_0000;
	localparam logic [ADDR_W-1:0]   VIRT_BASE_RST = 32'hC010_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_USABLE_PAGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIRT_BASE    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_VIRT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PHYS = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_VREAD,
		S_VEVAL,
		S_FAIL,
		S_MREAD,
		S_MWRITE,
		S_PREAD,
		S_PEVAL
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_VEVAL,
		OP_MWRITE,
		OP_PEVAL,
		OP_NOVIRT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic n_bad;
		logic v_found;
		logic v_end;
		logic m_done;
		logic p_found;
		logic p_end;
		logic p_last;
	} stat_t;

endpackage

// ----- src/bitmap_page_allocator_unit.sv -----
// First-fit page allocator over a virtual and a physical page bitmap, each held as a memory of
// eight-bit rows. After reset the unit clears both bitmaps, one row per cycle, so busy stays
// high until every row is cleared, before the first request is taken. A request scans rows for
// the virtual run, reading and evaluating each row, marks the run's rows by read and write, and
// probes rows for each physical frame from the lowest non-full row; results come one beat at
// a time, each on the outputs for a single cycle with valid high, and cannot be held off.
module bitmap_page_allocator_unit #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF,
	parameter int MAX_RUN    = bpa_pkg::MAX_RUN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bpa_pkg::COUNT_W-1:0]    page_count,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bpa_pkg::ADDR_W-1:0]     cfg_wdata,
	output logic                           valid,
	output logic [bpa_pkg::ADDR_W-1:0]     virt_addr,
	output logic [bpa_pkg::ADDR_W-1:0]     phys_addr,
	output logic [bpa_pkg::STATUS_W-1:0]   status,
	output logic                           last
);
	import bpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bpa_dp #(
		.POOL_PAGES (POOL_PAGES),
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_RUN    (MAX_RUN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.page_count (page_count),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.valid      (valid),
		.virt_addr  (virt_addr),
		.phys_addr  (phys_addr),
		.status     (status),
		.last       (last)
	);

endmodule

// ----- src/bpa_ctrl.sv -----
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t  cmd,
	output logic           busy
);
	import bpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		busy    = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = stat.n_bad ? S_FAIL : S_VREAD;
			end
			S_VREAD: begin
				state_d = S_VEVAL;
			end
			S_VEVAL: begin
				cmd.op = OP_VEVAL;
				if (stat.v_found) begin
					state_d = S_MREAD;
				end else if (stat.v_end) begin
					state_d = S_FAIL;
				end else begin
					state_d = S_VREAD;
				end
			end
			S_FAIL: begin
				cmd.op  = OP_NOVIRT;
				state_d = S_IDLE;
			end
			S_MREAD: begin
				state_d = S_MWRITE;
			end
			S_MWRITE: begin
				cmd.op  = OP_MWRITE;
				state_d = stat.m_done ? S_PREAD : S_MREAD;
			end
			S_PREAD: begin
				state_d = S_PEVAL;
			end
			S_PEVAL: begin
				cmd.op = OP_PEVAL;
				if (stat.p_found) begin
					state_d = stat.p_last ? S_IDLE : S_PREAD;
				end else if (stat.p_end) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_PREAD;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ----- src/bpa_dp.sv -----
module bpa_dp #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF,
	parameter int MAX_RUN    = bpa_pkg::MAX_RUN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpa_pkg::cmd_t                  cmd,
	output bpa_pkg::stat_t                 stat,
	input  logic [bpa_pkg::COUNT_W-1:0]    page_count,
	input  logic                           cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bpa_pkg::ADDR_W-1:0]     cfg_wdata,
	output logic                           valid,
	output logic [bpa_pkg::ADDR_W-1:0]     virt_addr,
	output logic [bpa_pkg::ADDR_W-1:0]     phys_addr,
	output logic [bpa_pkg::STATUS_W-1:0]   status,
	output logic                           last
);
	import bpa_pkg::*;

	localparam int ROWS = (POOL_PAGES + ROW_BITS - 1) / ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW   = $clog2(POOL_PAGES + 2 * MAX_RUN + 4 * ROW_BITS) + 1;
	localparam int RUN_W = COUNT_W + 1;

	logic [ROW_BITS-1:0] vmem [ROWS];
	logic [ROW_BITS-1:0] pmem [ROWS];
	logic [ROW_BITS-1:0] rd_v_q;
	logic [ROW_BITS-1:0] rd_p_q;

	logic [USABLE_W-1:0] usable_q;
	logic [ADDR_W-1:0]   phys_base_q;
	logic [ADDR_W-1:0]   virt_base_q;

	logic [RW-1:0]      row_q;
	logic [RW-1:0]      hint_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] k_q;
	logic [RUN_W-1:0]   run_q;
	logic [AW-1:0]      start_q;
	logic [AW-1:0]      vpage_q;

	logic [31:0]         lim32;
	logic [AW-1:0]       lim;
	logic [AW-1:0]       base;
	logic [AW-1:0]       row_end;
	logic [AW-1:0]       run_end;
	logic                row_last;

	logic                v_found;
	logic [RUN_W-1:0]    run_d;
	logic [2:0]          v_j;
	logic [AW-1:0]       v_start;
	logic [ROW_BITS-1:0] mask;
	logic                p_found;
	logic [2:0]          p_j;
	logic [AW-1:0]       frame;
	logic [ROW_BITS-1:0] p_new;
	logic [ADDR_W-1:0]   v_off;
	logic [ADDR_W-1:0]   p_off;

	assign lim32 = (32'(usable_q) > 32'(POOL_PAGES)) ? 32'(POOL_PAGES) : 32'(usable_q);
	assign lim      = AW'(lim32);
	assign base     = AW'({row_q, 3'b000});
	assign row_end  = base + AW'(ROW_BITS);
	assign run_end  = start_q + AW'(n_q);
	assign row_last = (row_q == RW'(ROWS - 1));

	always_comb begin
		logic [AW-1:0] idx;
		run_d   = run_q;
		v_found = 1'b0;
		v_j     = 3'd0;
		for (int j = 0; j < ROW_BITS; j++) begin
			idx = base + AW'(j);
			if (!v_found) begin
				if (!rd_v_q[j] && (idx < lim)) begin
					run_d = run_d + RUN_W'(1);
				end else begin
					run_d = '0;
				end
				if (run_d == RUN_W'(n_q)) begin
					v_found = 1'b1;
					v_j     = 3'(j);
				end
			end
		end
	end

	assign v_start = base + AW'(v_j) + AW'(1) - AW'(n_q);

	always_comb begin
		logic [AW-1:0] idx;
		for (int j = 0; j < ROW_BITS; j++) begin
			idx     = base + AW'(j);
			mask[j] = (idx >= start_q) && (idx < run_end);
		end
	end

	always_comb begin
		logic [AW-1:0] idx;
		p_found = 1'b0;
		p_j     = 3'd0;
		for (int j = ROW_BITS - 1; j >= 0; j--) begin
			idx = base + AW'(j);
			if (!rd_p_q[j] && (idx < lim)) begin
				p_found = 1'b1;
				p_j     = 3'(j);
			end
		end
	end

	assign frame = base + AW'(p_j);
	assign p_new = rd_p_q | (ROW_BITS'(1) << p_j);
	assign v_off = 32'(vpage_q) * 32'(PAGE_BYTES);
	assign p_off = 32'(frame) * 32'(PAGE_BYTES);

	always_comb begin
		stat.clr_done = row_last;
		stat.n_bad    = (n_q == '0) || (32'(n_q) > 32'(MAX_RUN));
		stat.v_found  = v_found;
		stat.v_end    = !v_found && (row_end >= lim);
		stat.m_done   = (row_end >= run_end);
		stat.p_found  = p_found;
		stat.p_end    = !p_found && (row_end >= lim);
		stat.p_last   = ((k_q + COUNT_W'(1)) == n_q);
	end

	always_ff @(posedge clk) begin
		rd_v_q <= vmem[row_q];
		if (cmd.op == OP_CLEAR) begin
			vmem[row_q] <= '0;
		end else if (cmd.op == OP_MWRITE) begin
			vmem[row_q] <= rd_v_q | mask;
		end
	end

	always_ff @(posedge clk) begin
		rd_p_q <= pmem[row_q];
		if (cmd.op == OP_CLEAR) begin
			pmem[row_q] <= '0;
		end else if (cmd.op == OP_PEVAL && p_found) begin
			pmem[row_q] <= p_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q    <= USABLE_RST;
			phys_base_q <= PHYS_BASE_RST;
			virt_base_q <= VIRT_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_USABLE_PAGES: usable_q    <= cfg_wdata[USABLE_W-1:0];
				CFG_PHYS_BASE:    phys_base_q <= cfg_wdata;
				CFG_VIRT_BASE:    virt_base_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			hint_q <= '0;
			valid  <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (cmd.op)
				OP_CLEAR: begin
					row_q <= row_q + RW'(1);
				end
				OP_LOAD: begin
					row_q <= '0;
				end
				OP_VEVAL: begin
					if (v_found) begin
						row_q <= RW'(v_start >> 3);
					end else if (!stat.v_end) begin
						row_q <= row_q + RW'(1);
					end
				end
				OP_MWRITE: begin
					row_q <= stat.m_done ? hint_q : row_q + RW'(1);
				end
				OP_PEVAL: begin
					valid <= p_found || stat.p_end;
					if (p_found) begin
						if (p_new == '1 && !row_last) begin
							hint_q <= row_q + RW'(1);
						end
					end else if (!stat.p_end) begin
						row_q <= row_q + RW'(1);
						if (rd_p_q == '1 && !row_last) begin
							hint_q <= row_q + RW'(1);
						end
					end
				end
				OP_NOVIRT: begin
					valid <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				n_q   <= page_count;
				k_q   <= '0;
				run_q <= '0;
			end
			OP_VEVAL: begin
				run_q <= run_d;
				if (v_found) begin
					start_q <= v_start;
					vpage_q <= v_start;
				end
			end
			OP_PEVAL: begin
				if (p_found) begin
					virt_addr <= virt_base_q + v_off;
					phys_addr <= phys_base_q + p_off;
					status    <= ST_OK;
					last      <= stat.p_last;
					k_q       <= k_q + COUNT_W'(1);
					vpage_q   <= vpage_q + AW'(1);
				end else begin
					virt_addr <= '0;
					phys_addr <= '0;
					status    <= ST_NO_PHYS;
					last      <= 1'b1;
				end
			end
			OP_NOVIRT: begin
				virt_addr <= '0;
				phys_addr <= '0;
				status    <= ST_NO_VIRT;
				last      <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- test/bpa_checker.sv -----
module bpa_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [bpa_pkg::COUNT_W-1:0]         page_count,
	input  logic                                cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [bpa_pkg::ADDR_W-1:0]          cfg_wdata,
	input  logic                                valid,
	input  logic [bpa_pkg::ADDR_W-1:0]          virt_addr,
	input  logic [bpa_pkg::ADDR_W-1:0]          phys_addr,
	input  logic [bpa_pkg::STATUS_W-1:0]        status,
	input  logic                                last,
	output int                                  fail_count,
	output int                                  pending
);
	import bpa_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0]   va;
		logic [ADDR_W-1:0]   pa;
		logic [STATUS_W-1:0] st;
		logic                lst;
	} page_beat_t;

	localparam int POOL = POOL_PAGES_DEF;

	bit                  vmap [POOL];
	bit                  pmap [POOL];
	logic [USABLE_W-1:0] lim_reg;
	logic [ADDR_W-1:0]   pbase;
	logic [ADDR_W-1:0]   vbase;
	page_beat_t          grants [$];

	function automatic logic [ADDR_W-1:0] frame_addr(logic [ADDR_W-1:0] base, int idx);
		logic [63:0] a;
		a = {32'd0, base} + 64'(idx) * 64'(PAGE_BYTES_DEF);
		return a[ADDR_W-1:0];
	endfunction

	task automatic allocate_pages(int n);
		int lim;
		int run;
		int first;
		int frame;
		page_beat_t b;
		lim = (lim_reg > POOL) ? POOL : int'(lim_reg);
		first = -1;
		run = 0;
		if (n >= 1 && n <= MAX_RUN_DEF) begin
			for (int i = 0; i < lim; i++) begin
				if (vmap[i]) begin
					run = 0;
				end else begin
					run++;
					if (run == n) begin
						first = i + 1 - n;
						break;
					end
				end
			end
		end
		if (first < 0) begin
			b = '{va: '0, pa: '0, st: ST_NO_VIRT, lst: 1'b1};
			grants.push_back(b);
			return;
		end
		for (int k = 0; k < n; k++)
			vmap[first + k] = 1'b1;
		for (int k = 0; k < n; k++) begin
			frame = -1;
			for (int i = 0; i < lim; i++) begin
				if (!pmap[i]) begin
					pmap[i] = 1'b1;
					frame = i;
					break;
				end
			end
			if (frame < 0) begin
				b = '{va: '0, pa: '0, st: ST_NO_PHYS, lst: 1'b1};
				grants.push_back(b);
				return;
			end
			b.va = frame_addr(vbase, first + k);
			b.pa = frame_addr(pbase, frame);
			b.st = ST_OK;
			b.lst = (k + 1 == n);
			grants.push_back(b);
		end
	endtask

	assign pending = grants.size();

	always @(posedge clk or negedge arst_n) begin
		page_beat_t e;
		if (!arst_n) begin
			for (int i = 0; i < POOL; i++) begin
				vmap[i] = 1'b0;
				pmap[i] = 1'b0;
			end
			lim_reg = USABLE_RST;
			pbase = PHYS_BASE_RST;
			vbase = VIRT_BASE_RST;
			grants.delete();
			fail_count = 0;
		end else begin
			if (valid) begin
				if (grants.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected beat: va %h pa %h st %0d last %b",
							virt_addr, phys_addr, status, last);
				end else begin
					e = grants.pop_front();
					if (e.va !== virt_addr || e.pa !== phys_addr || e.st !== status
						|| e.lst !== last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Mismatch: exp %h %h %0d %b, got %h %h %0d %b",
								e.va, e.pa, e.st, e.lst,
								virt_addr, phys_addr, status, last);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_USABLE_PAGES: lim_reg = cfg_wdata[USABLE_W-1:0];
					CFG_PHYS_BASE:    pbase = cfg_wdata;
					CFG_VIRT_BASE:    vbase = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				allocate_pages(int'(page_count));
		end
	end
endmodule

// ----- test/tb_bitmap_page_allocator_unit.sv -----
module tb_bitmap_page_allocator_unit;
	import bpa_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [COUNT_W-1:0]   page_count = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_USABLE_PAGES;
	logic [ADDR_W-1:0]    cfg_wdata = '0;
	logic                 valid;
	logic [ADDR_W-1:0]    virt_addr;
	logic [ADDR_W-1:0]    phys_addr;
	logic [STATUS_W-1:0]  status;
	logic                 last;
	int                   fail_count;
	int                   pending;

	always #5 clk = ~clk;

	bitmap_page_allocator_unit uut (.*);
	bpa_checker chk (.*);

	task automatic issue_request(logic [COUNT_W-1:0] n);
		start <= 1'b1;
		page_count <= n;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		page_count <= COUNT_W'($urandom);
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int items, int maxn);
		int burst;
		burst = 0;
		for (int i = 0; i < items; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 2) != 0)
					repeat ($urandom_range(1, 30)) @(posedge clk);
			end
			burst--;
			if ($urandom_range(0, 19) == 0)
				issue_request(COUNT_W'($urandom));
			else
				issue_request(COUNT_W'($urandom_range(1, maxn)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		issue_request(7'd1);
		issue_request(7'd64);
		issue_request(7'd0);
		issue_request(7'd65);
		issue_request(7'd127);
		issue_request(7'd3);
		write_reg(CFG_USABLE_PAGES, 32'd0);
		issue_request(7'd1);
		write_reg(CFG_USABLE_PAGES, 32'd140);
		write_reg(CFG_PHYS_BASE, 32'hFFFF_F000);
		write_reg(CFG_VIRT_BASE, 32'h0000_0000);
		issue_request(7'd2);
		issue_request(7'd64);
		issue_request(7'd20);
		drain();
		write_reg(CFG_USABLE_PAGES, 32'h1FFF);
		write_reg(CFG_PHYS_BASE, 32'h0);
		write_reg(CFG_VIRT_BASE, 32'hFFFF_FFFF);
		issue_request(7'd64);
		issue_request(7'd5);
		write_reg(CFG_USABLE_PAGES, 32'd200);
		write_reg(CFG_PHYS_BASE, $urandom);
		write_reg(CFG_VIRT_BASE, $urandom);
		random_phase(120, 8);
		drain();
		write_reg(CFG_USABLE_PAGES, 32'd4096);
		write_reg(CFG_PHYS_BASE, $urandom);
		write_reg(CFG_VIRT_BASE, $urandom);
		random_phase(120, 64);
		write_reg(CFG_USABLE_PAGES, 32'd3840);
		random_phase(110, 16);
		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#50000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
